FILE: rtl/core/sppd_pkg.sv
// Shared constants for the servo PWM / CPPM pulse decoder.
package sppd_pkg;

  localparam int NUM_CHANNELS = 3;

  localparam int CH_W    = 2;
  localparam int TS_W    = 16;
  localparam int TICK_W  = TS_W + 1;
  localparam int PMAX_W  = 15;
  localparam int WIDTH_W = 16;
  localparam int MARK_W  = 3;
  localparam int PH_W    = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MODE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMER_TOP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AUX_LOCAL  = 2'd3;

  localparam logic [TS_W-1:0]   TIMER_TOP_RST = 16'hFFFF;
  localparam logic [PMAX_W-1:0] PULSE_MAX_RST = 15'd2500;

  localparam logic [PH_W-1:0] PH_ANY  = 3'd0;
  localparam logic [PH_W-1:0] PH_IDLE = 3'd1;
  localparam logic [PH_W-1:0] PH_CH1  = 3'd2;
  localparam logic [PH_W-1:0] PH_CH2  = 3'd3;
  localparam logic [PH_W-1:0] PH_CH3  = 3'd4;

  localparam logic MODE_SERVO = 1'b0;
  localparam logic MODE_CPPM  = 1'b1;

endpackage

FILE: rtl/core/servo_pwm_ppm_pulse_decoder.sv
// Servo PWM and CPPM pulse decoder: capture events in, frame widths out.
//
//  channel   signals                                      direction
//  capture   in_valid, in_stall, channel, timestamp       request in
//  frame     out_valid, out_stall, steering_width,        request out
//            throttle_width, aux_width, aux_updated
//  config    cfg_we, cfg_index, cfg_data                  write only
//
// One capture is taken per cycle; its frame appears in the output register
// on the next cycle. The single output register sets the figure: a capture
// is stalled only while a frame sits there and out_stall is high.
// Synchronous reset clears all decoder state and loads register defaults.
module servo_pwm_ppm_pulse_decoder
  import sppd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CH_W-1:0]       channel,
  input  logic [TS_W-1:0]       timestamp,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [WIDTH_W-1:0]    steering_width,
  output logic [WIDTH_W-1:0]    throttle_width,
  output logic [WIDTH_W-1:0]    aux_width,
  output logic                  aux_updated,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic              mode;
  logic [TS_W-1:0]   timer_top;
  logic [PMAX_W-1:0] pulse_max_us;
  logic              aux_is_local_switch;

  logic              expect_falling [NUM_CHANNELS];
  logic [TS_W-1:0]   rise_time      [NUM_CHANNELS];
  logic [TICK_W-1:0] pulse_width    [NUM_CHANNELS];
  logic [MARK_W-1:0] seen_marks;
  logic [PH_W-1:0]   ppm_phase;
  logic [TS_W-1:0]   prev_edge_time;

  logic              expect_falling_next [NUM_CHANNELS];
  logic [TS_W-1:0]   rise_time_next      [NUM_CHANNELS];
  logic [TICK_W-1:0] pulse_width_next    [NUM_CHANNELS];
  logic [MARK_W-1:0] seen_marks_next;
  logic [PH_W-1:0]   ppm_phase_next;
  logic [TS_W-1:0]   prev_edge_time_next;

  logic              accept;
  logic              emit;
  logic              ch_ok;
  logic [TICK_W-1:0] pulse_diff;
  logic [TICK_W-1:0] gap;
  logic              is_sync;
  logic [TICK_W-1:0] frame_src   [NUM_CHANNELS];
  logic [WIDTH_W-1:0] frame_width [MARK_W];

  function automatic logic [TICK_W-1:0] tick_diff(
    input logic [TS_W-1:0] earlier,
    input logic [TS_W-1:0] later,
    input logic [TS_W-1:0] top
  );
    logic [TICK_W-1:0] wrap_add;
    wrap_add = (earlier > later) ? ({1'b0, top} + TICK_W'(1)) : '0;
    return {1'b0, later} + wrap_add - {1'b0, earlier};
  endfunction

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign ch_ok    = (32'(channel) < NUM_CHANNELS);

  always_comb begin
    for (int k = 0; k < MARK_W; k++) begin
      frame_width[k] = '0;
      if (k < NUM_CHANNELS) begin
        frame_width[k] = frame_src[k][TICK_W-1:1];
      end
    end
  end

  always_comb begin
    pulse_diff = '0;
    if (ch_ok) begin
      pulse_diff = tick_diff(rise_time[channel], timestamp, timer_top);
    end
    gap     = tick_diff(prev_edge_time, timestamp, timer_top);
    is_sync = (ppm_phase != PH_ANY) && (gap > TICK_W'({pulse_max_us, 1'b0}));
  end

  always_comb begin
    expect_falling_next = expect_falling;
    rise_time_next      = rise_time;
    pulse_width_next    = pulse_width;
    seen_marks_next     = seen_marks;
    ppm_phase_next      = ppm_phase;
    prev_edge_time_next = prev_edge_time;
    emit                = 1'b0;

    if (mode == MODE_SERVO) begin
      if (ch_ok) begin
        if (!expect_falling[channel]) begin
          rise_time_next[channel] = timestamp;
          if (seen_marks[channel]) begin
            emit = 1'b1;
            seen_marks_next = '0;
          end
          seen_marks_next[channel] = 1'b1;
        end else begin
          pulse_width_next[channel] = pulse_diff;
        end
        expect_falling_next[channel] = !expect_falling[channel];
      end
    end else begin
      prev_edge_time_next = timestamp;
      if (is_sync) begin
        if (seen_marks != '0) begin
          emit = 1'b1;
          seen_marks_next = '0;
        end
        ppm_phase_next = PH_CH1;
      end else begin
        case (ppm_phase)
          PH_CH1: begin
            pulse_width_next[0] = gap;
            seen_marks_next[0]  = 1'b1;
            ppm_phase_next      = PH_CH2;
          end
          PH_CH2: begin
            if (NUM_CHANNELS > 1) begin
              pulse_width_next[1] = gap;
            end
            seen_marks_next[1] = 1'b1;
            ppm_phase_next     = PH_CH3;
          end
          PH_CH3: begin
            if (NUM_CHANNELS > 2) begin
              pulse_width_next[2] = gap;
            end
            emit            = 1'b1;
            seen_marks_next = '0;
            ppm_phase_next  = PH_IDLE;
          end
          default: begin
            ppm_phase_next = PH_IDLE;
          end
        endcase
      end
    end

    frame_src = pulse_width_next;

    // clear widths once reported
    if (emit) begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        pulse_width_next[k] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode                <= MODE_SERVO;
      timer_top           <= TIMER_TOP_RST;
      pulse_max_us        <= PULSE_MAX_RST;
      aux_is_local_switch <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:      mode                <= cfg_data[0];
        REG_TIMER_TOP: timer_top           <= cfg_data[TS_W-1:0];
        REG_PULSE_MAX: pulse_max_us        <= cfg_data[PMAX_W-1:0];
        REG_AUX_LOCAL: aux_is_local_switch <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        expect_falling[k] <= 1'b0;
        rise_time[k]      <= '0;
        pulse_width[k]    <= '0;
      end
      seen_marks     <= '0;
      ppm_phase      <= PH_ANY;
      prev_edge_time <= '0;
    end else if (accept) begin
      expect_falling <= expect_falling_next;
      rise_time      <= rise_time_next;
      pulse_width    <= pulse_width_next;
      seen_marks     <= seen_marks_next;
      ppm_phase      <= ppm_phase_next;
      prev_edge_time <= prev_edge_time_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      steering_width <= frame_width[0];
      throttle_width <= frame_width[1];
      aux_width      <= aux_is_local_switch ? '0 : frame_width[2];
      aux_updated    <= !aux_is_local_switch;
    end
  end

  a_phase_in_range: assert property (@(posedge clk) disable iff (rst)
    ppm_phase == PH_ANY || ppm_phase == PH_IDLE || ppm_phase == PH_CH1 ||
    ppm_phase == PH_CH2 || ppm_phase == PH_CH3)
    else $error("ppm phase left its range");

  a_phase_no_return: assert property (@(posedge clk) disable iff (rst)
    ppm_phase != PH_ANY |=> ppm_phase != PH_ANY)
    else $error("ppm phase went back to wait-any");

  a_clear_after_emit: assert property (@(posedge clk) disable iff (rst)
    accept && emit |=> pulse_width[0] == '0 && seen_marks != '1)
    else $error("widths not cleared after frame");

  a_local_switch: assert property (@(posedge clk) disable iff (rst)
    out_valid && !aux_updated |-> aux_width == '0)
    else $error("aux width reported under local switch");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("capture taken over a held frame");

endmodule

FILE: tb/servo_pwm_ppm_pulse_decoder_test.sv
// Self-checking testbench for the servo PWM / CPPM pulse decoder.
module servo_pwm_ppm_pulse_decoder_test
  import sppd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS  = 1100;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_ITEMS    = 150;
  localparam int PRINT_LIMIT   = 200;

  typedef enum logic {REQ_CAPTURE, REQ_WRITE} req_kind_t;

  typedef struct {
    req_kind_t             kind;
    logic [CH_W-1:0]       ch;
    logic [TS_W-1:0]       ts;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } feed_item_t;

  typedef struct {
    logic [WIDTH_W-1:0] steering;
    logic [WIDTH_W-1:0] throttle;
    logic [WIDTH_W-1:0] aux;
    logic               aux_upd;
  } frame_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CH_W-1:0]       channel = '0;
  logic [TS_W-1:0]       timestamp = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [WIDTH_W-1:0]    steering_width;
  logic [WIDTH_W-1:0]    throttle_width;
  logic [WIDTH_W-1:0]    aux_width;
  logic                  aux_updated;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  servo_pwm_ppm_pulse_decoder DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .channel(channel), .timestamp(timestamp),
    .out_valid(out_valid), .out_stall(out_stall),
    .steering_width(steering_width), .throttle_width(throttle_width),
    .aux_width(aux_width), .aux_updated(aux_updated),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  feed_item_t capture_feed[$];
  frame_t     expected_frames[$];
  int         fail_count = 0;
  logic       calm_tail = 1'b0;

  // decoder copy
  logic                mode_r;
  logic [TS_W-1:0]     top_r;
  logic [PMAX_W-1:0]   pmax_r;
  logic                aux_local_r;
  logic                expect_fall [NUM_CHANNELS];
  logic [TS_W-1:0]     rise_t [NUM_CHANNELS];
  logic [TICK_W-1:0]   width_t [NUM_CHANNELS];
  logic [MARK_W-1:0]   marks;
  logic [PH_W-1:0]     phase;
  logic [TS_W-1:0]     prev_t;

  // stimulus generator state
  int unsigned gen_modulus = 65536;
  logic        gen_mode = MODE_SERVO;
  int unsigned gen_pmax = 2500;
  int unsigned wall = 0;
  int unsigned planned = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic void clear_decoder();
    mode_r = MODE_SERVO;
    top_r = TIMER_TOP_RST;
    pmax_r = PULSE_MAX_RST;
    aux_local_r = 1'b0;
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      expect_fall[k] = 1'b0;
      rise_t[k] = '0;
      width_t[k] = '0;
    end
    marks = '0;
    phase = PH_ANY;
    prev_t = '0;
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_MODE:      mode_r = data[0];
      REG_TIMER_TOP: top_r = data[TS_W-1:0];
      REG_PULSE_MAX: pmax_r = data[PMAX_W-1:0];
      REG_AUX_LOCAL: aux_local_r = data[0];
      default: ;
    endcase
  endfunction

  function automatic logic [TICK_W-1:0] tick_span(logic [TS_W-1:0] earlier,
                                                  logic [TS_W-1:0] later);
    logic [TICK_W-1:0] v;
    v = {1'b0, later};
    if (earlier > later) v = v + {1'b0, top_r} + TICK_W'(1);
    return v - {1'b0, earlier};
  endfunction

  function automatic void close_frame();
    frame_t f;
    f.steering = width_t[0][TICK_W-1:1];
    f.throttle = width_t[1][TICK_W-1:1];
    if (aux_local_r) begin
      f.aux = '0;
      f.aux_upd = 1'b0;
    end else begin
      f.aux = width_t[2][TICK_W-1:1];
      f.aux_upd = 1'b1;
    end
    expected_frames.push_back(f);
    for (int k = 0; k < NUM_CHANNELS; k++) width_t[k] = '0;
  endfunction

  function automatic void decode_capture(logic [CH_W-1:0] ch, logic [TS_W-1:0] ts);
    logic [TICK_W-1:0] gap;
    logic [MARK_W-1:0] bit_m;
    if (mode_r == MODE_SERVO) begin
      if (ch >= NUM_CHANNELS) return;
      bit_m = MARK_W'(1) << ch;
      if (!expect_fall[ch]) begin
        rise_t[ch] = ts;
        if ((marks & bit_m) != '0) begin
          close_frame();
          marks = '0;
        end
        marks = marks | bit_m;
      end else begin
        width_t[ch] = tick_span(rise_t[ch], ts);
      end
      expect_fall[ch] = !expect_fall[ch];
    end else begin
      gap = tick_span(prev_t, ts);
      prev_t = ts;
      if (phase != PH_ANY && gap > {1'b0, pmax_r, 1'b0}) begin
        if (marks != '0) begin
          close_frame();
          marks = '0;
        end
        phase = PH_CH1;
      end else if (phase == PH_CH1) begin
        width_t[0] = gap;
        marks = marks | MARK_W'(1);
        phase = PH_CH2;
      end else if (phase == PH_CH2) begin
        width_t[1] = gap;
        marks = marks | MARK_W'(2);
        phase = PH_CH3;
      end else if (phase == PH_CH3) begin
        width_t[2] = gap;
        close_frame();
        marks = '0;
        phase = PH_IDLE;
      end else begin
        phase = PH_IDLE;
      end
    end
  endfunction

  task automatic report_mismatch(string what);
    if (fail_count < PRINT_LIMIT) $display("ERROR at %0t ns: %s", $realtime, what);
    fail_count++;
  endtask

  task automatic check_field(string name, logic [WIDTH_W-1:0] got, logic [WIDTH_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  function automatic void add_capture(int unsigned ch, int unsigned ts);
    feed_item_t it;
    it.kind = REQ_CAPTURE;
    it.ch = CH_W'(ch);
    it.ts = TS_W'(ts);
    it.idx = '0;
    it.data = '0;
    capture_feed.push_back(it);
    if (gen_mode == MODE_CPPM || ch < NUM_CHANNELS) planned++;
  endfunction

  function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    feed_item_t it;
    it.kind = REQ_WRITE;
    it.ch = '0;
    it.ts = '0;
    it.idx = idx;
    it.data = data;
    capture_feed.push_back(it);
    case (idx)
      REG_MODE:      gen_mode = data[0];
      REG_TIMER_TOP: gen_modulus = int'(data) + 1;
      REG_PULSE_MAX: gen_pmax = int'(data[PMAX_W-1:0]);
      default: ;
    endcase
  endfunction

  function automatic int unsigned stamp(int unsigned t);
    return t % gen_modulus;
  endfunction

  function automatic int unsigned pulse_ticks();
    int unsigned hi;
    hi = (gen_modulus - 1 < 4400) ? gen_modulus - 1 : 4400;
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, gen_modulus - 1);
    return $urandom_range((hi < 1800) ? 0 : 1800, hi);
  endfunction

  function automatic void servo_frame();
    int unsigned w;
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      if ($urandom_range(0, 7) == 0) continue;
      w = pulse_ticks();
      add_capture(k, stamp(wall));
      add_capture(k, stamp(wall + w));
      wall += w + $urandom_range(20, 800);
    end
    wall += $urandom_range(2000, 30000);
  endfunction

  function automatic void cppm_frame();
    int unsigned lim, sync_lo, hi, pulses;
    lim = gen_modulus - 1;
    sync_lo = 2 * gen_pmax + 1;
    if (sync_lo <= lim)
      wall += $urandom_range(sync_lo, (sync_lo + 4000 < lim) ? sync_lo + 4000 : lim);
    else
      wall += lim;
    add_capture($urandom_range(0, 3), stamp(wall));
    pulses = ($urandom_range(0, 4) != 0) ? 3 : $urandom_range(0, 5);
    hi = 2 * gen_pmax;
    if (hi > lim) hi = lim;
    if (hi > 4400) hi = 4400;
    for (int i = 0; i < pulses; i++) begin
      wall += $urandom_range((hi > 1000) ? 1000 : 0, hi);
      add_capture($urandom_range(0, 3), stamp(wall));
    end
  endfunction

  function automatic void scatter(int unsigned n);
    for (int i = 0; i < n; i++) add_capture($urandom_range(0, 3), $urandom_range(0, 65535));
  endfunction

  function automatic void plan_directed();
    add_write(REG_MODE, CFG_DATA_W'(MODE_SERVO));
    add_write(REG_AUX_LOCAL, '0);
    add_capture(0, 0);
    add_capture(0, 3000);
    add_capture(1, 65000);
    add_capture(1, 1000);
    add_capture(3, 16'hFFFF);
    add_capture(2, 16'hFFFF);
    add_capture(2, 16'hFFFF);
    add_capture(0, 20000);
    add_capture(0, 21000);
    add_write(REG_AUX_LOCAL, 16'd1);
    add_write(REG_TIMER_TOP, 16'h0FFF);
    add_capture(1, 16'hFFFF);
    add_capture(1, 16'h0001);
    add_capture(1, 16'h0800);
    add_write(REG_MODE, CFG_DATA_W'(MODE_CPPM));
    add_write(REG_TIMER_TOP, 16'hFFFF);
    add_write(REG_PULSE_MAX, 16'd2500);
    add_write(REG_AUX_LOCAL, '0);
    add_capture(2, 100);
    add_capture(3, 300);
    add_capture(0, 9000);
    add_capture(1, 11000);
    add_capture(0, 13500);
    add_capture(2, 16000);
    add_capture(0, 30000);
    add_capture(1, 32200);
    add_capture(0, 60000);
    add_write(REG_PULSE_MAX, 16'h7FFF);
    add_capture(0, 59999);
    add_capture(0, 61999);
    add_capture(0, 61998);
    add_write(REG_PULSE_MAX, 16'h8000);
    add_capture(0, 61998);
    add_capture(0, 61999);
  endfunction

  function automatic void plan_random();
    int unsigned target, seg_end, r;
    logic [15:0] junk;
    logic [15:0] top;
    logic [15:0] pmax;
    target = planned + RANDOM_ITEMS;
    while (planned < target) begin
      r = $urandom_range(0, 9);
      if (r < 5)      top = 16'hFFFF;
      else if (r < 7) top = 16'($urandom_range(16384, 65534));
      else if (r < 9) top = 16'($urandom_range(2000, 8191));
      else            top = 16'($urandom_range(0, 15));
      r = $urandom_range(0, 9);
      if (r < 5)       pmax = 16'd2500;
      else if (r == 5) pmax = 16'd0;
      else if (r == 6) pmax = 16'h7FFF;
      else             pmax = 16'($urandom_range(500, 6000));
      pmax[15] = 1'($urandom_range(0, 1));
      junk = 16'($urandom);
      add_write(REG_MODE, {junk[15:1], 1'($urandom_range(0, 1))});
      add_write(REG_TIMER_TOP, top);
      add_write(REG_PULSE_MAX, pmax);
      junk = 16'($urandom);
      add_write(REG_AUX_LOCAL, {junk[15:1], 1'($urandom_range(0, 3) == 0)});
      seg_end = planned + $urandom_range(40, 110);
      while (planned < seg_end) begin
        if (gen_modulus < 16 || $urandom_range(0, 6) == 0) scatter($urandom_range(1, 4));
        else if (gen_mode == MODE_CPPM) cppm_frame();
        else servo_frame();
      end
    end
  endfunction

  int idle_left = 0;
  int quiet_cycles = 0;

  always @(posedge clk) begin : drive
    feed_item_t head;
    logic we_next;
    if (rst) begin
      in_valid <= 1'b0;
      cfg_we <= 1'b0;
      quiet_cycles = 0;
    end else begin
      we_next = 1'b0;
      if (in_valid && !in_stall) decode_capture(channel, timestamp);
      if (in_valid || out_valid || expected_frames.size() != 0) quiet_cycles = 0;
      else if (quiet_cycles < SETTLE_CYCLES) quiet_cycles++;
      calm_tail <= (capture_feed.size() < TAIL_ITEMS);
      if (in_valid && in_stall) begin
        // hold the stalled request
      end else if (idle_left != 0) begin
        in_valid <= 1'b0;
        idle_left--;
      end else if (capture_feed.size() == 0) begin
        in_valid <= 1'b0;
      end else if (capture_feed[0].kind == REQ_WRITE) begin
        in_valid <= 1'b0;
        if (quiet_cycles >= SETTLE_CYCLES) begin
          head = capture_feed.pop_front();
          we_next = 1'b1;
          cfg_index <= head.idx;
          cfg_data <= head.data;
          apply_register(head.idx, head.data);
        end
      end else if (capture_feed.size() >= TAIL_ITEMS && $urandom_range(0, 9) == 0) begin
        in_valid <= 1'b0;
        idle_left = $urandom_range(1, 18) - 1;
      end else begin
        head = capture_feed.pop_front();
        in_valid <= 1'b1;
        channel <= head.ch;
        timestamp <= head.ts;
      end
      cfg_we <= we_next;
    end
  end

  int stall_left = 0;

  always @(posedge clk) begin : watch
    frame_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_frames.size() == 0) begin
          report_mismatch("frame with none pending");
        end else begin
          want = expected_frames.pop_front();
          check_field("steering_width", steering_width, want.steering);
          check_field("throttle_width", throttle_width, want.throttle);
          check_field("aux_width", aux_width, want.aux);
          check_field("aux_updated", WIDTH_W'(aux_updated), WIDTH_W'(want.aux_upd));
        end
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (!calm_tail && $urandom_range(0, 11) == 0) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(1, 18) - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    clear_decoder();
    plan_directed();
    plan_random();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk);
    while (capture_feed.size() != 0 || in_valid || expected_frames.size() != 0);
    repeat (12) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
